// ===== rtl/core/aftp_pkg.sv =====
package aftp_pkg;

    localparam int unsigned KinvQ24 = 10188014;
    localparam int unsigned AtanLen = 28;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [1:0] {
        t_kind_full  = 2'd0,
        t_kind_azim  = 2'd1,
        t_kind_range = 2'd2,
        t_kind_other = 2'd3
    } t_kind;

    localparam logic OpState = 1'b0;
    localparam logic OpFix   = 1'b1;

    localparam logic CfgSync  = 1'b0;
    localparam logic CfgNoise = 1'b1;

endpackage

// ===== rtl/core/acoustic_fix_to_position_top.sv =====
// a fix with a result runs ST_CHECK, then ST_PRE, ST_PRE2, ST_LOAD, ST_ROT, ST_ABS and again
// ST_PRE to ST_ROT, then ST_SUM; an azimuth fix first searches up to HISTORY_DEPTH entries
// one word in flight: the next word is taken in ST_IDLE after a state update, a stored or dropped
// fix, an unpaired azimuth fix or a result; both rotations use the shared cordic add/shift unit;
// a result not yet taken holds the block in its last step
// synchronous active-low reset presets config; clears anchor, history count, pointer, not history
module acoustic_fix_to_position_top #(
    parameter int HISTORY_DEPTH = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, stamp_ms, north_mm, east_mm, var_north, var_east, fix_kind,
    // source_id, range_mm, bearing, elevation, zero fill
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_stamp_ms, pos_north_mm, pos_east_mm, noise_north, noise_east
    output logic [159:0] m_tdata
);

    localparam int HW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int STEPS0 = ANGLE_BITS + 4;
    localparam int STEPS  = (STEPS0 < int'(aftp_pkg::AtanLen)) ? STEPS0
                                                               : int'(aftp_pkg::AtanLen);
    localparam logic [31:0] AngMask = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [23:0] Kinv = 24'(aftp_pkg::KinvQ24);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_READ, ST_MATCH, ST_PRE, ST_PRE2, ST_LOAD, ST_ROT,
        ST_ABS, ST_SUM
    } t_state;

    // input unpack
    wire        w_op    = s_tdata[0];
    wire [31:0] w_stamp = s_tdata[32:1];
    wire [31:0] w_north = s_tdata[64:33];
    wire [31:0] w_east  = s_tdata[96:65];
    wire [31:0] w_vn    = s_tdata[128:97];
    wire [31:0] w_ve    = s_tdata[160:129];
    wire [1:0]  w_kind  = s_tdata[162:161];
    wire [7:0]  w_src   = s_tdata[170:163];
    wire [21:0] w_range = s_tdata[192:171];
    wire [15:0] w_bear  = s_tdata[208:193];
    wire [15:0] w_elev  = s_tdata[224:209];

    t_state r_state;
    logic [15:0] r_sync;
    logic [31:0] r_noise;
    logic        r_ref_valid;
    logic [31:0] r_ref_stamp;
    logic signed [31:0] r_ref_n, r_ref_e;
    logic [31:0] r_ref_vn, r_ref_ve;
    logic [HW-1:0] r_wptr;
    logic [CW-1:0] r_count;
    logic [63:0] r_hist [HISTORY_DEPTH];
    logic [63:0] r_rd;

    // current item
    logic [31:0] r_stamp, r_vn, r_ve;
    logic [1:0]  r_kind;
    logic [7:0]  r_src;
    logic [21:0] r_range;
    logic [31:0] r_bear, r_elev;
    logic [CW-1:0] r_k;
    logic [HW-1:0] r_ridx;
    logic        r_second;
    logic [4:0]  r_i;
    logic signed [63:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic signed [63:0] r_mag;
    logic [63:0] r_prod;
    logic        r_out_valid;
    logic [159:0] r_out;

    logic w_out_load;

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    // output register free or being emptied this cycle
    assign w_out_load = (r_state == ST_SUM) && (!r_out_valid || m_tready);

    // history read address
    logic [HW-1:0] w_prev_idx;
    assign w_prev_idx = (r_ridx == '0) ? HW'(HISTORY_DEPTH - 1) : r_ridx - HW'(1);

    // pairing compare
    logic signed [32:0] w_dst;
    logic [32:0] w_adiff;
    logic w_match;
    always_comb begin
        w_dst   = $signed({1'b0, r_stamp}) - $signed({1'b0, r_rd[31:0]});
        w_adiff = w_dst[32] ? 33'(-w_dst) : 33'(w_dst);
        w_match = (r_rd[61:54] == r_src) && (r_rd[63:62] != r_kind)
            && (w_adiff < {17'd0, r_sync});
    end

    // staleness
    logic signed [32:0] w_age;
    assign w_age = $signed({1'b0, w_stamp}) - $signed({1'b0, r_ref_stamp});

    // gain prescale: magnitude times kinv in two 20-bit halves on one multiplier
    logic [19:0] w_mul_a;
    logic [43:0] w_pp;
    assign w_mul_a = (r_state == ST_PRE2) ? r_mag[39:20] : r_mag[19:0];
    assign w_pp    = {24'd0, w_mul_a} * {20'd0, Kinv};

    // shared rotation step
    logic signed [63:0] w_dx, w_dy;
    logic [31:0] w_at;
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = aftp_pkg::atan_turn(r_i);

    // rotation start: quarter-turn fold
    logic [31:0] w_ang, w_angf;
    logic w_fold;
    always_comb begin
        w_ang  = (r_second ? r_bear : r_elev) & AngMask;
        w_fold = (w_ang + 32'h4000_0000) >= 32'h8000_0000;
        w_angf = w_fold ? w_ang + 32'h8000_0000 : w_ang;
    end

    // output sums
    logic signed [63:0] w_rn, w_re;
    logic signed [33:0] w_pn, w_pe;
    logic [33:0] w_sn, w_se;
    always_comb begin
        w_rn = (r_x + 64'sd32768) >>> 16;
        w_re = (r_y + 64'sd32768) >>> 16;
        w_pn = 34'(w_rn) + 34'(r_ref_n);
        w_pe = 34'(w_re) + 34'(r_ref_e);
        w_sn = {2'd0, r_ref_vn} + {2'd0, r_vn} + {2'd0, r_noise};
        w_se = {2'd0, r_ref_ve} + {2'd0, r_ve} + {2'd0, r_noise};
    end

    function automatic logic [31:0] sat_s(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -34'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sync      <= 16'd2000;
            r_noise     <= 32'd1;
            r_ref_valid <= 1'b0;
            r_ref_stamp <= '0;
            r_ref_n     <= '0;
            r_ref_e     <= '0;
            r_ref_vn    <= '0;
            r_ref_ve    <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aftp_pkg::CfgSync:  r_sync  <= i_cfg_data[15:0];
                    aftp_pkg::CfgNoise: r_noise <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) r_out_valid <= 1'b1;
            else if (m_tready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        r_stamp <= w_stamp;
                        r_vn    <= w_vn;
                        r_ve    <= w_ve;
                        r_kind  <= w_kind;
                        r_src   <= w_src;
                        r_range <= w_range;
                        r_bear  <= {w_bear, 16'd0};
                        r_elev  <= {w_elev, 16'd0};
                        if (w_op == aftp_pkg::OpState) begin
                            r_ref_valid <= 1'b1;
                            r_ref_stamp <= w_stamp;
                            r_ref_n     <= w_north;
                            r_ref_e     <= w_east;
                            r_ref_vn    <= w_vn;
                            r_ref_ve    <= w_ve;
                        end else begin
                            if (w_age > 33'sd0 && w_age > $signed({17'd0, r_sync}))
                                r_ref_valid <= 1'b0;
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    r_second <= 1'b0;
                    r_mag    <= 64'({r_range, 16'd0});
                    if (!r_ref_valid) begin
                        r_state <= ST_IDLE;
                    end else if (r_kind != aftp_pkg::t_kind_full) begin
                        r_hist[r_wptr] <= {r_kind, r_src, r_range, r_stamp};
                        r_wptr <= (r_wptr == HW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + HW'(1);
                        if (r_count < CW'(HISTORY_DEPTH)) r_count <= r_count + CW'(1);
                        r_ridx <= r_wptr;
                        r_k    <= '0;
                        r_state <= (r_kind == aftp_pkg::t_kind_azim) ? ST_READ : ST_IDLE;
                    end else begin
                        r_state <= ST_PRE;
                    end
                end
                ST_READ: begin
                    // r_count already holds the updated count
                    if (r_k >= r_count) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_rd    <= r_hist[r_ridx];
                        r_ridx  <= w_prev_idx;
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    if (w_match) begin
                        r_mag   <= 64'({r_rd[53:32], 16'd0});
                        r_state <= ST_PRE;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_PRE: begin
                    r_prod  <= {20'd0, w_pp};
                    r_state <= ST_PRE2;
                end
                ST_PRE2: begin
                    r_prod  <= r_prod + {w_pp, 20'd0};
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_x     <= w_fold ? -$signed({24'd0, r_prod[63:24]})
                                      : $signed({24'd0, r_prod[63:24]});
                    r_y     <= '0;
                    r_z     <= $signed({w_angf[31], w_angf});
                    r_i     <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - $signed({1'b0, w_at});
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + $signed({1'b0, w_at});
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(STEPS - 1))
                        r_state <= r_second ? ST_SUM : ST_ABS;
                end
                ST_ABS: begin
                    r_mag    <= r_x[63] ? -r_x : r_x;
                    r_second <= 1'b1;
                    r_state  <= ST_PRE;
                end
                ST_SUM: begin
                    // wait here while the previous word is still unread
                    if (w_out_load) begin
                        r_out <= {(w_se[33:32] != 2'd0) ? 32'hFFFF_FFFF : w_se[31:0],
                                  (w_sn[33:32] != 2'd0) ? 32'hFFFF_FFFF : w_sn[31:0],
                                  sat_s(w_pe), sat_s(w_pn), r_stamp};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> (r_i < 5'(STEPS))) else $error("step overrun");

endmodule
